/* src/vrank_pkg.sv */
// ----------------------------------------------------------------------------
// vrank_pkg - shared types and constants for the value rank block
// Field widths of the request and response words, and the control group
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package vrank_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned RANK_W  = 6;

   // largest rank that fits the response word; the 64th response closes a run
   localparam logic [RANK_W-1:0] RANK_MAX    = '1;
   localparam logic [RANK_W-1:0] RESULT_LAST = '1;

   typedef struct packed {
      logic shift;   // residents move one cell towards the head
      logic flush;   // end of a run: all cells empty out
   } vrank_ctrl_type;

endpackage

/* src/vrank_cell.sv */
// ----------------------------------------------------------------------------
// vrank_cell - one cell of the ranking chain
// Holds one resident value with its count of values <= it, and a token slot
// for a value travelling down the chain. A passing token <= the resident bumps
// its count, and gains a count if >= it; an empty cell keeps the token it meets.
// ----------------------------------------------------------------------------
module vrank_cell
   import vrank_pkg::*;
#(
   parameter int unsigned CountWidth = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vrank_ctrl_type              ctrl,
   // token from the previous cell
   input  logic                        tok_valid_i,
   input  logic signed [VALUE_W-1:0]   tok_value_i,
   input  logic [CountWidth-1:0]       tok_count_i,
   // token to the next cell
   output logic                        tok_valid_o,
   output logic signed [VALUE_W-1:0]   tok_value_o,
   output logic [CountWidth-1:0]       tok_count_o,
   // resident of the next cell, taken when the chain shifts
   input  logic                        nb_valid_i,
   input  logic [CountWidth-1:0]       nb_count_i,
   // own resident, seen by the previous cell
   output logic                        res_valid_o,
   output logic [CountWidth-1:0]       res_count_o
);

   logic                      res_valid_ff, res_valid_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [CountWidth-1:0]     res_count_ff, res_count_in;
   logic                      tok_valid_ff, tok_valid_in;
   logic signed [VALUE_W-1:0] tok_value_ff, tok_value_in;
   logic [CountWidth-1:0]     tok_count_ff, tok_count_in;
   logic                      tok_le_res;
   logic                      res_le_tok;

   assign tok_le_res = (tok_value_i <= res_value_ff);
   assign res_le_tok = (res_value_ff <= tok_value_i);

   always_comb begin
      res_valid_in = res_valid_ff;
      res_value_in = res_value_ff;
      res_count_in = res_count_ff;
      tok_valid_in = 1'b0;
      tok_value_in = tok_value_i;
      tok_count_in = tok_count_i;
      priority if (ctrl.flush) begin
         res_valid_in = 1'b0;
      end else if (ctrl.shift) begin
         res_valid_in = nb_valid_i;
         res_count_in = nb_count_i;
      end else if (tok_valid_i) begin
         if (!res_valid_ff) begin
            // first free cell: the token settles, counting itself
            res_valid_in = 1'b1;
            res_value_in = tok_value_i;
            res_count_in = tok_count_i + CountWidth'(1);
         end else begin
            tok_valid_in = 1'b1;
            if (tok_le_res) begin
               res_count_in = res_count_ff + CountWidth'(1);
            end
            if (res_le_tok) begin
               tok_count_in = tok_count_i + CountWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         tok_valid_ff <= tok_valid_in;
      end
      res_value_ff <= res_value_in;
      res_count_ff <= res_count_in;
      tok_value_ff <= tok_value_in;
      tok_count_ff <= tok_count_in;
   end

   assign tok_valid_o = tok_valid_ff;
   assign tok_value_o = tok_value_ff;
   assign tok_count_o = tok_count_ff;
   assign res_valid_o = res_valid_ff;
   assign res_count_o = res_count_ff;

endmodule

/* src/value_rank_assignment.sv */
// ----------------------------------------------------------------------------
// value_rank_assignment - rank of each value of a sequence
// Loads signed values until a word marked last, then returns each value's
// position in ascending order (count of values <= it, minus 1), in load order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one value per word, req_last closes the sequence. Words are
//   taken one per cycle while loading. Each enters a chain of MAX_COUNT cells
//   and walks one cell per cycle, comparing against every resident it passes.
//   Words beyond MAX_COUNT in a sequence are dropped (a dropped last word
//   still closes it).
//   After the last word req_stall is held high while the chain drains, until
//   the final value has walked to its cell. Then one rsp word per stored value
//   follows, one per cycle while rsp_stall is low, straight from the head cell;
//   rsp_last_rank marks the final one (at most 64 words are returned, the
//   rank saturates at 63).
//   rsp_stall holds the head cell and the chain; nothing is lost.
//   Reset empties the chain and returns to loading; it needs no clearing
//   pass.
// ----------------------------------------------------------------------------
module value_rank_assignment
   import vrank_pkg::*;
#(
   parameter int unsigned MAX_COUNT = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [RANK_W-1:0]         rsp_rank,
   output logic                      rsp_last_rank
);

   localparam int unsigned CW = $clog2(MAX_COUNT + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         load_cnt_ff;
   logic [RANK_W-1:0]     emit_cnt_ff;

   logic                  req_take;
   logic                  inject;
   logic                  busy;
   logic                  rsp_take;
   logic [31:0]           count_m1;
   vrank_ctrl_type        ctrl;

   logic [MAX_COUNT:0]        tok_valid_w;
   logic signed [VALUE_W-1:0] tok_value_w [0:MAX_COUNT-1];
   logic [CW-1:0]             tok_count_w [0:MAX_COUNT-1];
   logic [MAX_COUNT:0]        res_valid_w;
   logic [CW-1:0]             res_count_w [0:MAX_COUNT];

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign inject    = req_take && (load_cnt_ff != CW'(MAX_COUNT));
   assign busy      = |tok_valid_w[MAX_COUNT:1];

   assign ctrl.shift = rsp_take;
   assign ctrl.flush = rsp_take && rsp_last_rank;

   // head of the chain: fresh word, nothing counted yet
   assign tok_valid_w[0] = inject;
   assign tok_value_w[0] = req_value;
   assign tok_count_w[0] = '0;

   // tail has no neighbour to shift in from
   assign res_valid_w[MAX_COUNT] = 1'b0;
   assign res_count_w[MAX_COUNT] = '0;

   for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
      if (i < MAX_COUNT - 1) begin : g_mid
         vrank_cell #(.CountWidth(CW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .tok_valid_i (tok_valid_w[i]),
            .tok_value_i (tok_value_w[i]),
            .tok_count_i (tok_count_w[i]),
            .tok_valid_o (tok_valid_w[i+1]),
            .tok_value_o (tok_value_w[i+1]),
            .tok_count_o (tok_count_w[i+1]),
            .nb_valid_i  (res_valid_w[i+1]),
            .nb_count_i  (res_count_w[i+1]),
            .res_valid_o (res_valid_w[i]),
            .res_count_o (res_count_w[i])
         );
      end else begin : g_tail
         // injection is capped at MAX_COUNT, so a token never leaves the tail
         vrank_cell #(.CountWidth(CW)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .tok_valid_i (tok_valid_w[i]),
            .tok_value_i (tok_value_w[i]),
            .tok_count_i (tok_count_w[i]),
            .tok_valid_o (tok_valid_w[i+1]),
            .tok_value_o (),
            .tok_count_o (),
            .nb_valid_i  (res_valid_w[i+1]),
            .nb_count_i  (res_count_w[i+1]),
            .res_valid_o (res_valid_w[i]),
            .res_count_o (res_count_w[i])
         );
      end
   end

   assign count_m1      = 32'(res_count_w[0]) - 32'd1;
   assign rsp_rank      = (count_m1 > 32'(RANK_MAX)) ? RANK_MAX : count_m1[RANK_W-1:0];
   assign rsp_last_rank = !res_valid_w[1] || (emit_cnt_ff == RESULT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         emit_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (inject) begin
                  load_cnt_ff <= load_cnt_ff + CW'(1);
               end
               if (req_take && req_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!busy) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_take) begin
                  emit_cnt_ff <= emit_cnt_ff + RANK_W'(1);
                  if (rsp_last_rank) begin
                     state_ff    <= ST_LOAD;
                     load_cnt_ff <= '0;
                     emit_cnt_ff <= '0;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

`ifndef SYNTHESIS
   // responses come only from a settled chain
   a_emit_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && res_valid_w[0]))
      else $error("response offered while a word is still in the chain");

   // a finished run leaves the chain empty and the counters cleared
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.flush |=> (!res_valid_w[0] && load_cnt_ff == '0 && emit_cnt_ff == '0))
      else $error("chain not emptied after the final response");

   // stored values never outrun the cells
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff <= CW'(MAX_COUNT))
      else $error("load count beyond chain length");

   // while loading, the emit counter stays at rest
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (emit_cnt_ff == '0))
      else $error("emit counter moved outside a response run");
`endif

endmodule
